>>> src/fnvde_pkg.sv
// Package for the FNV-1a digest expander: hash constants, the hash type and
// the operand struct that drives the shared step unit. No dependencies.
package fnvde_pkg;

    typedef logic [31:0] t_hash;

    localparam t_hash       FNV_BASIS = 32'd2166136261;
    localparam t_hash       FNV_PRIME = 32'd16777619;
    localparam logic [10:0] MIX_MUL   = 11'd31;
    localparam logic [10:0] MIX_ADD   = 11'd17;

    // step: ((hash ^ pre) * prime) ^ post
    typedef struct packed {
        logic [7:0] pre;
        t_hash      post;
    } t_step_op;

endpackage

>>> src/fnvde_if.sv
// Valid/ready channel interfaces for the message words and the digest words.
// Depends on nothing.
interface fnvde_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last,
                    output ready);
endinterface

interface fnvde_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] digest_byte;
    logic [5:0] digest_index;
    logic       digest_last;

    modport source (output valid, output digest_byte, output digest_index,
                    output digest_last, input ready);
    modport sink   (input valid, input digest_byte, input digest_index,
                     input digest_last, output ready);
endinterface

>>> src/fnvde_step_unit.sv
// Shared hash step unit: one 32x32 multiply by the FNV prime, framed by xors.
// Depends on fnvde_pkg.
module fnvde_step_unit (
    input  fnvde_pkg::t_hash    i_hash,
    input  fnvde_pkg::t_step_op i_op,
    output fnvde_pkg::t_hash    o_hash
);

    fnvde_pkg::t_hash w_mix;
    fnvde_pkg::t_hash w_prod;

    assign w_mix  = i_hash ^ {24'd0, i_op.pre};
    assign w_prod = w_mix * fnvde_pkg::FNV_PRIME;
    assign o_hash = w_prod ^ i_op.post;

endmodule

>>> src/fnv1a_digest_expander.sv
// Top level of the FNV-1a digest expander: sequencer, hash register, output word.
// Depends on fnvde_pkg, fnvde_if and fnvde_step_unit.

// Message words are taken one per clock while the block is absorbing; each
// word with has_byte set folds its byte into the 32-bit hash through the shared
// multiply unit in that same cycle. A word marked last starts a digest run of
// DIGEST_BYTES output words, one per clock while the sink is ready; the same
// multiply unit advances the hash after each word but the last, and no message
// word is taken until the run's final word is accepted. The hash returns to the
// offset basis after every run.
module fnv1a_digest_expander #(
    parameter int DIGEST_BYTES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fnvde_in_if.sink           i_in,
    fnvde_out_if.source        o_out
);

    localparam int           KW     = (DIGEST_BYTES > 4) ? $clog2(DIGEST_BYTES) : 2;
    localparam logic [KW-1:0] K_LAST = KW'(DIGEST_BYTES - 1);

    localparam logic ST_ABSORB = 1'b0;
    localparam logic ST_EMIT   = 1'b1;

    logic                r_state, n_state;
    logic [KW-1:0]       r_k, n_k;
    fnvde_pkg::t_hash    r_hash, n_hash;

    fnvde_pkg::t_step_op w_op;
    fnvde_pkg::t_hash    w_step;
    logic [10:0]         w_mix;
    logic                w_in_acc;
    logic                w_out_acc;

    fnvde_step_unit u_step (
        .i_hash (r_hash),
        .i_op   (w_op),
        .o_hash (w_step)
    );

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;
    assign w_mix     = 11'(r_k) * fnvde_pkg::MIX_MUL + fnvde_pkg::MIX_ADD;

    assign i_in.ready         = (r_state == ST_ABSORB);
    assign o_out.valid        = (r_state == ST_EMIT);
    assign o_out.digest_index = 6'(r_k);
    assign o_out.digest_last  = (r_k == K_LAST);

    always_comb begin
        case (r_k[1:0])
            2'd0:    o_out.digest_byte = r_hash[7:0];
            2'd1:    o_out.digest_byte = r_hash[15:8];
            2'd2:    o_out.digest_byte = r_hash[23:16];
            default: o_out.digest_byte = r_hash[31:24];
        endcase
    end

    always_comb begin
        if (r_state == ST_ABSORB) begin
            w_op.pre  = i_in.data_byte;
            w_op.post = '0;
        end else begin
            w_op.pre  = '0;
            w_op.post = 32'(w_mix);
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_hash  = r_hash;
        case (r_state)
            ST_ABSORB: begin
                if (w_in_acc) begin
                    if (i_in.has_byte) begin
                        n_hash = w_step;
                    end
                    if (i_in.last) begin
                        n_state = ST_EMIT;
                        n_k     = '0;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_acc) begin
                    if (r_k == K_LAST) begin
                        n_hash  = fnvde_pkg::FNV_BASIS;
                        n_state = ST_ABSORB;
                    end else begin
                        n_hash = w_step;
                        n_k    = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_ABSORB;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ABSORB;
            r_k     <= '0;
            r_hash  <= fnvde_pkg::FNV_BASIS;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_hash  <= n_hash;
        end
    end

    a_no_accept_during_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("message word taken during digest run");

    a_last_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.last) |=> (o_out.valid && o_out.digest_index == 6'd0))
        else $error("digest run did not start at index zero");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !o_out.digest_last) |=>
            (o_out.valid && r_k == $past(r_k) + 1'b1))
        else $error("digest index did not advance by one");

    a_basis_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out.digest_last) |=>
            (r_hash == fnvde_pkg::FNV_BASIS && i_in.ready))
        else $error("hash not back at offset basis after run");

endmodule
